[rtl/ssfla_pkg.sv]
package ssfla_pkg;

	localparam int HEAP_BYTES   = 65536;
	localparam int ALIGN_BYTES  = 8;
	localparam int HEADER_BYTES = 16;
	localparam int FREE_SLOTS   = 64;

	localparam int SPLIT_MIN = HEADER_BYTES * 2;
	localparam int HDR_DEPTH = (HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;

	localparam int OFF_W    = $clog2(HEAP_BYTES);
	localparam int SIZE_W   = OFF_W + 1;
	localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
	localparam int HDR_AW   = $clog2(HDR_DEPTH);
	localparam int SLOT_AW  = $clog2(FREE_SLOTS);
	localparam int CNT_W    = SLOT_AW + 1;
	localparam int ENTRY_W  = OFF_W + SIZE_W;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO_REQ  = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NO_FIT    = 3'd3,
		ST_TABLE_FULL = 3'd4,
		ST_NULL_FREE = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CMP,
		S_REM_RD,
		S_REM_WR,
		S_INS_RD,
		S_INS_CMP,
		S_SHF_RD,
		S_SHF_WR,
		S_INS_PUT,
		S_HDR_RD,
		S_HDR_WAIT,
		S_HDR_WR,
		S_DONE
	} state_t;

endpackage

[rtl/ssfla_ram.sv]
module ssfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/size_sorted_free_list_allocator_unit.sv]
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   kind, request_bytes, block_address
// out      out  out_valid/out_stall status, payload_address, free_bytes
// cfg      in   cfg_write_en        cfg_write_data (heap_base)
//
// each free table entry visited by a search, remove shift or insert shift takes a read state
//   and a compare or write state (one table port)
// in_stall is high from acceptance until the result is loaded into the output register
// a waiting result holds the sequencer in its last state until out_stall drops
// reset leaves one free block covering the heap; no clearing pass
module size_sorted_free_list_allocator_unit import ssfla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] request_bytes,
	input  logic [31:0] block_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] payload_address,
	output logic [16:0] free_bytes,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data
);

	state_t state_q, state_d;

	logic [31:0]       base_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  pos_q, pos_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [SIZE_W-1:0] bytes_q, bytes_d;
	logic [SIZE_W-1:0] key_q, key_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [OFF_W-1:0]  off_q, off_d;
	logic [OFF_W-1:0]  ins_off_q, ins_off_d;
	logic              op_free_q, op_free_d;
	status_t           res_status_q, res_status_d;
	logic [31:0]       res_payload_q, res_payload_d;
	logic              init_q;
	logic              rd0_q;

	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [31:0]       out_payload_q;
	logic [16:0]       out_bytes_q;
	logic              out_load;

	logic               tbl_we;
	logic [SLOT_AW-1:0] tbl_waddr, tbl_raddr;
	logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;
	logic               hdr_we;
	logic [SIZE_W-1:0]  hdr_rdata;

	logic [OFF_W-1:0]  eff_off;
	logic [SIZE_W-1:0] eff_size;
	logic              cmp_lt;
	logic [SIZE_W-1:0] total;
	logic [31:0]       free_off;
	logic [SIZE_W:0]   bytes_sum;
	logic [SIZE_W-1:0] split_rem;

	ssfla_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_SLOTS)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	ssfla_ram #(.WIDTH(SIZE_W), .DEPTH(HDR_DEPTH)) u_header (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (off_q[OFF_W-1:ALIGN_SH]),
		.wdata (size_q),
		.raddr (off_q[OFF_W-1:ALIGN_SH]),
		.rdata (hdr_rdata)
	);

	// entry 0 reads as the whole heap until first written
	assign eff_off  = (rd0_q && init_q) ? '0 : tbl_rdata[ENTRY_W-1:SIZE_W];
	assign eff_size = (rd0_q && init_q) ? SIZE_W'(HEAP_BYTES) : tbl_rdata[SIZE_W-1:0];
	assign cmp_lt   = eff_size < key_q;

	assign total = (SIZE_W'(request_bytes) + SIZE_W'(HEADER_BYTES + ALIGN_BYTES - 1))
		& ~SIZE_W'(ALIGN_BYTES - 1);
	assign free_off  = block_address - base_q - 32'(HEADER_BYTES);
	assign bytes_sum = {1'b0, bytes_q} + {1'b0, key_q};
	assign split_rem = size_q - key_q;

	assign in_stall        = state_q != S_IDLE;
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign payload_address = out_payload_q;
	assign free_bytes      = out_bytes_q;

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		pos_d         = pos_q;
		idx_d         = idx_q;
		bytes_d       = bytes_q;
		key_d         = key_q;
		size_d        = size_q;
		off_d         = off_q;
		ins_off_d     = ins_off_q;
		op_free_d     = op_free_q;
		res_status_d  = res_status_q;
		res_payload_d = res_payload_q;
		tbl_we        = 1'b0;
		tbl_waddr     = pos_q[SLOT_AW-1:0];
		tbl_wdata     = {eff_off, eff_size};
		tbl_raddr     = pos_q[SLOT_AW-1:0];
		hdr_we        = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_free_d     = kind;
					res_payload_d = '0;
					res_status_d  = ST_OK;
					pos_d         = '0;
					if (!kind) begin
						key_d = total;
						if (request_bytes == '0) begin
							res_status_d = ST_ZERO_REQ;
							state_d      = S_DONE;
						end else if (total >= SIZE_W'(HEAP_BYTES)) begin
							res_status_d = ST_TOO_LARGE;
							state_d      = S_DONE;
						end else begin
							state_d = S_FIND_RD;
						end
					end else begin
						off_d = free_off[OFF_W-1:0];
						if (block_address == '0) begin
							res_status_d = ST_NULL_FREE;
							state_d      = S_DONE;
						end else if (free_off >= 32'(HEAP_BYTES) ||
							free_off[ALIGN_SH:0] != '0 && ALIGN_SH > 0 &&
							free_off[ALIGN_SH-1:0] != '0) begin
							res_status_d = ST_TOO_LARGE;
							state_d      = S_DONE;
						end else if (cnt_q >= CNT_W'(FREE_SLOTS)) begin
							res_status_d = ST_TABLE_FULL;
							state_d      = S_DONE;
						end else begin
							state_d = S_HDR_RD;
						end
					end
				end
			end
			S_FIND_RD: begin
				if (pos_q == cnt_q) begin
					res_status_d = ST_NO_FIT;
					state_d      = S_DONE;
				end else begin
					state_d = S_FIND_CMP;
				end
			end
			S_FIND_CMP: begin
				if (cmp_lt) begin
					pos_d   = pos_q + 1'b1;
					state_d = S_FIND_RD;
				end else begin
					off_d   = eff_off;
					size_d  = eff_size;
					state_d = S_REM_RD;
				end
			end
			S_REM_RD: begin
				tbl_raddr = SLOT_AW'(pos_q + 1'b1);
				if (pos_q + 1'b1 < cnt_q) begin
					state_d = S_REM_WR;
				end else begin
					cnt_d = cnt_q - 1'b1;
					if (split_rem > SIZE_W'(SPLIT_MIN)) begin
						ins_off_d = off_q + key_q[OFF_W-1:0];
						key_d     = split_rem;
						size_d    = key_q;
						pos_d     = '0;
						state_d   = S_INS_RD;
					end else begin
						state_d = S_HDR_WR;
					end
				end
			end
			S_REM_WR: begin
				tbl_we  = 1'b1;
				pos_d   = pos_q + 1'b1;
				state_d = S_REM_RD;
			end
			S_INS_RD: begin
				if (pos_q == cnt_q) begin
					idx_d   = cnt_q;
					state_d = S_SHF_RD;
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (cmp_lt) begin
					pos_d   = pos_q + 1'b1;
					state_d = S_INS_RD;
				end else begin
					idx_d   = cnt_q;
					state_d = S_SHF_RD;
				end
			end
			S_SHF_RD: begin
				tbl_raddr = SLOT_AW'(idx_q - 1'b1);
				if (idx_q > pos_q) begin
					state_d = S_SHF_WR;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_SHF_WR: begin
				tbl_we    = 1'b1;
				tbl_waddr = idx_q[SLOT_AW-1:0];
				idx_d     = idx_q - 1'b1;
				state_d   = S_SHF_RD;
			end
			S_INS_PUT: begin
				tbl_we    = 1'b1;
				tbl_wdata = {ins_off_q, key_q};
				cnt_d     = cnt_q + 1'b1;
				if (op_free_q) begin
					bytes_d = (bytes_sum > (SIZE_W+1)'(HEAP_BYTES)) ?
						SIZE_W'(HEAP_BYTES) : bytes_sum[SIZE_W-1:0];
					state_d = S_DONE;
				end else begin
					state_d = S_HDR_WR;
				end
			end
			S_HDR_RD: begin
				state_d = S_HDR_WAIT;
			end
			S_HDR_WAIT: begin
				key_d     = hdr_rdata;
				ins_off_d = off_q;
				pos_d     = '0;
				state_d   = S_INS_RD;
			end
			S_HDR_WR: begin
				hdr_we        = 1'b1;
				bytes_d       = (bytes_q > size_q) ? bytes_q - size_q : '0;
				res_payload_d = base_q + 32'(off_q) + 32'(HEADER_BYTES);
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			cnt_q       <= CNT_W'(1);
			bytes_q     <= SIZE_W'(HEAP_BYTES);
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			bytes_q <= bytes_d;
			if (cfg_write_en) begin
				base_q <= cfg_write_data;
			end
			if (tbl_we && tbl_waddr == '0) begin
				init_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q         <= pos_d;
		idx_q         <= idx_d;
		key_q         <= key_d;
		size_q        <= size_d;
		off_q         <= off_d;
		ins_off_q     <= ins_off_d;
		op_free_q     <= op_free_d;
		res_status_q  <= res_status_d;
		res_payload_q <= res_payload_d;
		rd0_q         <= tbl_raddr == '0;
		if (out_load) begin
			out_status_q  <= res_status_q;
			out_payload_q <= res_payload_q;
			out_bytes_q   <= bytes_q;
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FREE_SLOTS)) else $error("free table count overflow");

	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q <= SIZE_W'(HEAP_BYTES)) else $error("free byte count above heap size");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHF_WR |-> idx_q > pos_q) else $error("insert shift past position");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> state_q == S_IDLE && out_valid_q) else $error("result load lost");
`endif

endmodule

[sim/size_sorted_free_list_allocator_unit_tb.sv]
`timescale 1ns / 1ps

module size_sorted_free_list_allocator_unit_tb;
	import ssfla_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		logic        kind;
		logic [15:0] req;
		logic [31:0] addr;
	} heap_op_t;

	typedef struct {
		status_t     status;
		logic [31:0] payload;
		logic [16:0] free;
	} heap_res_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        kind = 0;
	logic [15:0] request_bytes = 0;
	logic [31:0] block_address = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [31:0] payload_address;
	logic [16:0] free_bytes;
	logic        cfg_write_en = 0;
	logic [31:0] cfg_write_data = 0;

	size_sorted_free_list_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .request_bytes(request_bytes), .block_address(block_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .payload_address(payload_address), .free_bytes(free_bytes),
		.cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	heap_op_t  pending_ops[$];
	heap_res_t expected_res[$];
	int        errors = 0;
	int        cycles = 0;
	int        tx_idle = 0;
	int        rx_idle = 0;
	bit        hold_req = 0;
	int        hold_cnt = 0;
	bit        in_acc = 0;

	// shadow allocator state
	logic [31:0] heap_base_sh = 0;
	logic [15:0] blk_off [FREE_SLOTS];
	logic [16:0] blk_size [FREE_SLOTS];
	int          blk_count;
	logic [16:0] bytes_left;
	logic [16:0] hdr_size [HDR_DEPTH];
	bit          hdr_set [HDR_DEPTH];
	int          live_offs[$];
	int          used_offs[$];

	task automatic table_drop(int pos);
		for (int i = pos; i + 1 < blk_count; i++) begin
			blk_off[i] = blk_off[i + 1];
			blk_size[i] = blk_size[i + 1];
		end
		blk_count--;
	endtask

	task automatic table_put(logic [15:0] off, logic [16:0] size);
		int pos;
		pos = 0;
		while (pos < blk_count && blk_size[pos] < size) pos++;
		for (int i = blk_count; i > pos; i--) begin
			blk_off[i] = blk_off[i - 1];
			blk_size[i] = blk_size[i - 1];
		end
		blk_off[pos] = off;
		blk_size[pos] = size;
		blk_count++;
	endtask

	task automatic alloc_predict(heap_op_t op);
		heap_res_t r;
		int total, pos, off, size;
		r.status = ST_OK;
		r.payload = 0;
		if (op.kind == 1'b0) begin
			if (op.req == 0) begin
				r.status = ST_ZERO_REQ;
			end else begin
				total = op.req + HEADER_BYTES;
				if (total % ALIGN_BYTES != 0) total += ALIGN_BYTES - total % ALIGN_BYTES;
				if (total >= HEAP_BYTES) begin
					r.status = ST_TOO_LARGE;
				end else begin
					pos = 0;
					while (pos < blk_count && blk_size[pos] < total) pos++;
					if (pos >= blk_count) begin
						r.status = ST_NO_FIT;
					end else begin
						off = blk_off[pos];
						size = blk_size[pos];
						table_drop(pos);
						if (size - total > SPLIT_MIN && blk_count < FREE_SLOTS) begin
							table_put(16'(off + total), 17'(size - total));
							size = total;
						end
						hdr_size[off / ALIGN_BYTES] = 17'(size);
						if (!hdr_set[off / ALIGN_BYTES]) used_offs.push_back(off);
						hdr_set[off / ALIGN_BYTES] = 1;
						live_offs.push_back(off);
						bytes_left = (bytes_left > size) ? 17'(bytes_left - size) : 17'd0;
						r.payload = heap_base_sh + 32'(off) + 32'(HEADER_BYTES);
					end
				end
			end
		end else begin
			logic [31:0] foff;
			foff = op.addr - heap_base_sh - 32'(HEADER_BYTES);
			if (op.addr == 0) begin
				r.status = ST_NULL_FREE;
			end else if (foff >= HEAP_BYTES || foff % ALIGN_BYTES != 0) begin
				r.status = ST_TOO_LARGE;
			end else if (blk_count >= FREE_SLOTS) begin
				r.status = ST_TABLE_FULL;
			end else begin
				size = hdr_size[foff / ALIGN_BYTES];
				table_put(foff[15:0], 17'(size));
				if (int'(bytes_left) + size > HEAP_BYTES) bytes_left = 17'(HEAP_BYTES);
				else bytes_left = 17'(bytes_left + size);
			end
		end
		r.free = bytes_left;
		pending_ops.push_back(op);
		expected_res.push_back(r);
	endtask

	task automatic issue(logic k, logic [15:0] req, logic [31:0] addr);
		heap_op_t op;
		op.kind = k;
		op.req = req;
		op.addr = addr;
		alloc_predict(op);
	endtask

	function automatic logic [31:0] addr_of(int off);
		return heap_base_sh + 32'(off) + 32'(HEADER_BYTES);
	endfunction

	task automatic random_op();
		int r, idx;
		logic [31:0] a, foff;
		r = $urandom_range(99);
		if (r < 50 || (r < 85 && live_offs.size() == 0)) begin
			r = $urandom_range(99);
			if (r < 2) issue(1'b0, 16'd0, $urandom);
			else if (r < 5) issue(1'b0, 16'($urandom), $urandom);
			else if (r < 15) issue(1'b0, 16'($urandom_range(1, 8000)), $urandom);
			else issue(1'b0, 16'($urandom_range(1, 256)), $urandom);
		end else if (r < 85) begin
			idx = $urandom_range(live_offs.size() - 1);
			a = addr_of(live_offs[idx]);
			live_offs.delete(idx);
			issue(1'b1, 16'($urandom), a);
		end else if (r < 90 && used_offs.size() > 0) begin
			issue(1'b1, 16'($urandom), addr_of(used_offs[$urandom_range(used_offs.size() - 1)]));
		end else if (r < 95) begin
			a = $urandom;
			foff = a - heap_base_sh - 32'(HEADER_BYTES);
			if (foff < HEAP_BYTES && foff % ALIGN_BYTES == 0 && !hdr_set[foff / ALIGN_BYTES])
				a = a ^ 32'd1;
			issue(1'b1, 16'($urandom), a);
		end else begin
			issue(1'b1, 16'($urandom), 32'd0);
		end
	endtask

	task automatic drain_and_config(logic [31:0] base);
		while (pending_ops.size() != 0 || expected_res.size() != 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
		cfg_write_en = 1;
		cfg_write_data = base;
		@(negedge clk);
		cfg_write_en = 0;
		heap_base_sh = base;
	endtask

	// driver
	always @(posedge clk) in_acc <= in_valid && !in_stall;

	always @(negedge clk) begin
		heap_op_t cur;
		if (arst_n && (!in_valid || in_acc)) begin
			if (pending_ops.size() > 0 && $urandom_range(99) >= tx_idle) begin
				cur = pending_ops.pop_front();
				in_valid <= 1;
				kind <= cur.kind;
				request_bytes <= cur.req;
				block_address <= cur.addr;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_req && hold_cnt == 0) begin
			hold_req = 0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle);
		end
	end

	// monitor
	always @(posedge clk) begin
		heap_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_res.size() == 0) begin
				$error("unexpected transaction status=%0d", status);
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					errors++;
				end
				if (payload_address !== e.payload) begin
					$error("payload_address expected %h actual %h", e.payload, payload_address);
					errors++;
				end
				if (free_bytes !== e.free) begin
					$error("free_bytes expected %0d actual %0d", e.free, free_bytes);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] bases [6];
		int          tx_set [6];
		int          rx_set [6];
		bases = '{32'd0, 32'hFFFF_FFF0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF};
		bases[2] = $urandom;
		bases[4] = $urandom;
		tx_set = '{0, 63, 0, 18, 0, 18};
		rx_set = '{0, 0, 63, 18, 0, 63};
		blk_off[0] = 0;
		blk_size[0] = 17'(HEAP_BYTES);
		blk_count = 1;
		bytes_left = 17'(HEAP_BYTES);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		for (int ph = 0; ph < 6; ph++) begin
			drain_and_config(bases[ph]);
			tx_idle = tx_set[ph];
			rx_idle = rx_set[ph];
			if (ph == 0) begin
				issue(1'b0, 16'd0, 32'hFFFF_FFFF);
				issue(1'b0, 16'hFFFF, 32'd0);
				issue(1'b0, 16'd65520, 32'd0);
				issue(1'b0, 16'd65513, 32'd0);
				issue(1'b0, 16'd65512, 32'd0);
				issue(1'b0, 16'd8, 32'd0);
				issue(1'b1, 16'hFFFF, addr_of(0));
				issue(1'b1, 16'd0, addr_of(0));
				live_offs.delete();
				issue(1'b1, 16'd0, 32'd0);
				issue(1'b1, 16'd0, addr_of(0) + 32'd4);
				issue(1'b1, 16'd0, addr_of(HEAP_BYTES));
				issue(1'b1, 16'd0, 32'hFFFF_FFFF);
				issue(1'b0, 16'd1, 32'd0);
				issue(1'b0, 16'd17, 32'd0);
				issue(1'b0, 16'd24, 32'd0);
				issue(1'b0, 16'd30000, 32'd0);
			end
			if (ph == 4) begin
				// small blocks freed one by one fill the table
				for (int i = 0; i < 90; i++) issue(1'b0, 16'($urandom_range(1, 64)), $urandom);
				while (live_offs.size() > 0) begin
					issue(1'b1, 16'($urandom), addr_of(live_offs[0]));
					live_offs.delete(0);
				end
				hold_req = 1;
			end
			for (int i = 0; i < 250; i++) random_op();
		end
		while (pending_ops.size() != 0 || expected_res.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/ssfla_pkg.sv
rtl/ssfla_ram.sv
rtl/size_sorted_free_list_allocator_unit.sv
sim/size_sorted_free_list_allocator_unit_tb.sv
